/* hw/rtl/landmark_coplanarity_check_defines.svh */
// Assertion macros shared by the verification checkers of the
// landmark coplanarity check.
`ifndef LANDMARK_COPLANARITY_CHECK_DEFINES_SVH
`define LANDMARK_COPLANARITY_CHECK_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define LCC_ASSERT_NOW(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define LCC_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* hw/rtl/lcc_pkg.sv */
// ----------------------------------------------------------------------------
// Landmark coplanarity check package
// Widths, reset values and the shared multiply-accumulate control type.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package lcc_pkg;

    localparam int COORD_W   = 20;
    localparam int DIFF_W    = 21;
    localparam int NORM_W    = 42;
    localparam int HALF_W    = 21;
    localparam int MUL_A_W   = 22;
    localparam int PROD_W    = MUL_A_W + DIFF_W;
    localparam int ACC_W     = 64;
    localparam int TOL_W     = 21;
    localparam int STEP_W    = 3;

    localparam logic [TOL_W-1:0]  TOL_RESET = TOL_W'(16);
    localparam logic [STEP_W-1:0] LAST_STEP = STEP_W'(5);

    typedef struct packed {
        logic signed [COORD_W-1:0] x;
        logic signed [COORD_W-1:0] y;
        logic signed [COORD_W-1:0] z;
    } point_t;

    typedef struct packed {
        logic signed [DIFF_W-1:0] x;
        logic signed [DIFF_W-1:0] y;
        logic signed [DIFF_W-1:0] z;
    } diff_t;

    typedef struct packed {
        logic signed [NORM_W-1:0] x;
        logic signed [NORM_W-1:0] y;
        logic signed [NORM_W-1:0] z;
    } normal_t;

    // One multiply-accumulate issue: subtract instead of add, scale the
    // product by 2^21, and close the running sum after this product.
    typedef struct packed {
        logic valid;
        logic neg;
        logic shift;
        logic last;
    } mac_op_t;

endpackage

`default_nettype wire

/* hw/rtl/lcc_mac.sv */
// ----------------------------------------------------------------------------
// Landmark coplanarity check multiply-accumulate unit
// A 22 x 21 bit signed multiplier with a registered product, followed by a
// 64-bit accumulator that delivers one sum per closed group of products.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module lcc_mac (
    input  wire                                  aclk,
    input  wire                                  aresetn,
    input  lcc_pkg::mac_op_t                     op,
    input  wire logic signed [lcc_pkg::MUL_A_W-1:0] opa,
    input  wire logic signed [lcc_pkg::DIFF_W-1:0]  opb,
    output logic                                 res_valid,
    output logic signed [lcc_pkg::ACC_W-1:0]     res
);
    import lcc_pkg::*;

    logic signed [PROD_W-1:0] prod_reg;
    mac_op_t                  tag_reg;
    logic signed [ACC_W-1:0]  acc_reg;
    logic signed [ACC_W-1:0]  res_reg;
    logic                     res_valid_reg;
    logic signed [ACC_W-1:0]  term;
    logic signed [ACC_W-1:0]  acc_next;

    always_comb begin
        term = ACC_W'(prod_reg);
        if (tag_reg.shift) begin
            term = term <<< HALF_W;
        end
        acc_next = tag_reg.neg ? (acc_reg - term) : (acc_reg + term);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            tag_reg       <= '0;
            acc_reg       <= '0;
            res_valid_reg <= 1'b0;
        end else begin
            tag_reg       <= op;
            res_valid_reg <= 1'b0;
            if (tag_reg.valid) begin
                if (tag_reg.last) begin
                    res_reg       <= acc_next;
                    acc_reg       <= '0;
                    res_valid_reg <= 1'b1;
                end else begin
                    acc_reg <= acc_next;
                end
            end
        end
        prod_reg <= PROD_W'(opa * opb);
    end

    assign res_valid = res_valid_reg;
    assign res       = res_reg;

endmodule

`default_nettype wire

/* hw/rtl/landmark_coplanarity_check.sv */
// ----------------------------------------------------------------------------
// Landmark coplanarity check
// Loads 2N landmark points and reports whether the fixed or float set is
// degenerate, that is equal, collinear or coplanar within a tolerance.
// ----------------------------------------------------------------------------
// Points are accepted one per cycle: the first POINTS_PER_SET form the fixed
// set and the next POINTS_PER_SET the float set. After the last point the
// block stops accepting transactions and checks the fixed set, then the float
// set unless the fixed set is already degenerate, and returns one coplanar
// flag. Every cross and dot product goes through a single 22 x 21 bit
// multiplier, six products per point, and each stored point is read through
// the single read port of the store. Each set fetches its first point,
// compares the following points with it, tests each further point for
// collinearity or against the plane and then closes; a result still waiting
// on the output holds the block until taken.
`timescale 1ns / 1ps
`default_nettype none

module landmark_coplanarity_check #(
    parameter int POINTS_PER_SET = 4
) (
    input  wire                                      aclk,
    input  wire                                      aresetn,
    input  wire                                      cfg_wr_en,
    input  wire logic [lcc_pkg::TOL_W-1:0]           cfg_wr_data,
    input  wire                                      s_valid,
    output logic                                     s_ready,
    input  wire logic signed [lcc_pkg::COORD_W-1:0]  s_coord_x,
    input  wire logic signed [lcc_pkg::COORD_W-1:0]  s_coord_y,
    input  wire logic signed [lcc_pkg::COORD_W-1:0]  s_coord_z,
    output logic                                     m_valid,
    input  wire                                      m_ready,
    output logic                                     m_coplanar
);
    import lcc_pkg::*;

    localparam int DEPTH = 2 * POINTS_PER_SET;
    localparam int AW    = $clog2(DEPTH);
    localparam int IW    = $clog2(POINTS_PER_SET);

    localparam logic [AW-1:0] LAST_LOAD = AW'(DEPTH - 1);
    localparam logic [AW-1:0] SET_BASE  = AW'(POINTS_PER_SET);
    localparam logic [IW-1:0] LAST_IDX  = IW'(POINTS_PER_SET - 1);

    typedef enum logic [3:0] {
        S_LOAD,
        S_FETCH_P1,
        S_GOT_P1,
        S_FETCH_EQ,
        S_EQ,
        S_FETCH_CR,
        S_LD_CR,
        S_CROSS,
        S_CR_WAIT,
        S_FETCH_DOT,
        S_LD_DOT,
        S_DOT,
        S_DOT_WAIT,
        S_SET_END
    } state_t;

    point_t               mem [DEPTH];
    point_t               rd_data_reg;
    logic [AW-1:0]        rd_addr;

    state_t               state_reg;
    logic [AW-1:0]        load_cnt_reg;
    logic [IW-1:0]        idx_reg;
    logic                 set_sel_reg;
    logic                 set_flag_reg;
    logic [STEP_W-1:0]    step_reg;
    logic [1:0]           res_cnt_reg;
    logic [TOL_W-1:0]     tol_reg;
    logic                 m_valid_reg;
    logic                 m_coplanar_reg;

    point_t               p1_reg;
    diff_t                edge_reg;
    diff_t                d_reg;
    normal_t              normal_reg;

    diff_t                rd_diff;
    logic                 same_as_p1;
    logic                 idx_last;
    logic                 normal_nonzero;
    logic [ACC_W-1:0]     dot_mag;
    logic                 result_load;

    mac_op_t                     mac_op;
    logic signed [MUL_A_W-1:0]   mac_a;
    logic signed [DIFF_W-1:0]    mac_b;
    logic                        mac_res_valid;
    logic signed [ACC_W-1:0]     mac_res;

    assign rd_addr = set_sel_reg ? (SET_BASE + AW'(idx_reg)) : AW'(idx_reg);

    assign result_load = (state_reg == S_SET_END) && (set_flag_reg || set_sel_reg)
                      && (!m_valid_reg || m_ready);

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            mem[load_cnt_reg] <= '{x: s_coord_x, y: s_coord_y, z: s_coord_z};
        end
        rd_data_reg <= mem[rd_addr];
    end

    always_comb begin
        rd_diff.x      = DIFF_W'(rd_data_reg.x) - DIFF_W'(p1_reg.x);
        rd_diff.y      = DIFF_W'(rd_data_reg.y) - DIFF_W'(p1_reg.y);
        rd_diff.z      = DIFF_W'(rd_data_reg.z) - DIFF_W'(p1_reg.z);
        same_as_p1     = (rd_data_reg == p1_reg);
        idx_last       = (idx_reg == LAST_IDX);
        normal_nonzero = (normal_reg.x != '0) || (normal_reg.y != '0)
                      || (mac_res[NORM_W-1:0] != '0);
        dot_mag        = mac_res[ACC_W-1] ? ACC_W'(-mac_res) : ACC_W'(mac_res);
    end

    always_comb begin
        mac_op       = '0;
        mac_op.valid = (state_reg == S_CROSS) || (state_reg == S_DOT);
        mac_a        = '0;
        mac_b        = '0;
        if (state_reg == S_CROSS) begin
            mac_op.last = step_reg[0];
            mac_op.neg  = step_reg[0];
            unique case (step_reg)
                3'd0: begin mac_a = MUL_A_W'(d_reg.y); mac_b = edge_reg.z; end
                3'd1: begin mac_a = MUL_A_W'(d_reg.z); mac_b = edge_reg.y; end
                3'd2: begin mac_a = MUL_A_W'(d_reg.z); mac_b = edge_reg.x; end
                3'd3: begin mac_a = MUL_A_W'(d_reg.x); mac_b = edge_reg.z; end
                3'd4: begin mac_a = MUL_A_W'(d_reg.x); mac_b = edge_reg.y; end
                3'd5: begin mac_a = MUL_A_W'(d_reg.y); mac_b = edge_reg.x; end
                default: begin mac_a = '0; mac_b = '0; end
            endcase
        end else begin
            mac_op.last  = (step_reg == LAST_STEP);
            mac_op.shift = step_reg[0];
            unique case (step_reg)
                3'd0: begin
                    mac_a = $signed({1'b0, normal_reg.x[HALF_W-1:0]});
                    mac_b = d_reg.x;
                end
                3'd1: begin
                    mac_a = MUL_A_W'($signed(normal_reg.x[NORM_W-1:HALF_W]));
                    mac_b = d_reg.x;
                end
                3'd2: begin
                    mac_a = $signed({1'b0, normal_reg.y[HALF_W-1:0]});
                    mac_b = d_reg.y;
                end
                3'd3: begin
                    mac_a = MUL_A_W'($signed(normal_reg.y[NORM_W-1:HALF_W]));
                    mac_b = d_reg.y;
                end
                3'd4: begin
                    mac_a = $signed({1'b0, normal_reg.z[HALF_W-1:0]});
                    mac_b = d_reg.z;
                end
                3'd5: begin
                    mac_a = MUL_A_W'($signed(normal_reg.z[NORM_W-1:HALF_W]));
                    mac_b = d_reg.z;
                end
                default: begin mac_a = '0; mac_b = '0; end
            endcase
        end
    end

    lcc_mac u_mac (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .op        (mac_op),
        .opa       (mac_a),
        .opb       (mac_b),
        .res_valid (mac_res_valid),
        .res       (mac_res)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= S_LOAD;
            load_cnt_reg <= '0;
            idx_reg      <= '0;
            set_sel_reg  <= 1'b0;
            set_flag_reg <= 1'b0;
            step_reg     <= '0;
            res_cnt_reg  <= '0;
            tol_reg      <= TOL_RESET;
            m_valid_reg  <= 1'b0;
        end else begin
            if (cfg_wr_en) begin
                tol_reg <= cfg_wr_data;
            end
            if (result_load) begin
                m_valid_reg    <= 1'b1;
                m_coplanar_reg <= set_flag_reg;
            end else if (m_valid_reg && m_ready) begin
                m_valid_reg <= 1'b0;
            end
            if ((state_reg == S_CROSS || state_reg == S_CR_WAIT) && mac_res_valid) begin
                res_cnt_reg <= res_cnt_reg + 2'd1;
                unique case (res_cnt_reg)
                    2'd0:    normal_reg.x <= mac_res[NORM_W-1:0];
                    2'd1:    normal_reg.y <= mac_res[NORM_W-1:0];
                    default: normal_reg.z <= mac_res[NORM_W-1:0];
                endcase
            end

            unique case (state_reg)
                S_LOAD: begin
                    if (s_valid) begin
                        if (load_cnt_reg == LAST_LOAD) begin
                            load_cnt_reg <= '0;
                            set_sel_reg  <= 1'b0;
                            idx_reg      <= '0;
                            state_reg    <= S_FETCH_P1;
                        end else begin
                            load_cnt_reg <= load_cnt_reg + AW'(1);
                        end
                    end
                end
                S_FETCH_P1: begin
                    state_reg <= S_GOT_P1;
                end
                S_GOT_P1: begin
                    p1_reg    <= rd_data_reg;
                    idx_reg   <= IW'(1);
                    state_reg <= S_FETCH_EQ;
                end
                S_FETCH_EQ: begin
                    state_reg <= S_EQ;
                end
                S_EQ: begin
                    if (!same_as_p1) begin
                        edge_reg <= rd_diff;
                    end
                    if (idx_last) begin
                        set_flag_reg <= 1'b1;
                        state_reg    <= S_SET_END;
                    end else begin
                        idx_reg   <= idx_reg + IW'(1);
                        state_reg <= same_as_p1 ? S_FETCH_EQ : S_FETCH_CR;
                    end
                end
                S_FETCH_CR: begin
                    state_reg <= S_LD_CR;
                end
                S_LD_CR: begin
                    d_reg       <= rd_diff;
                    step_reg    <= '0;
                    res_cnt_reg <= '0;
                    state_reg   <= S_CROSS;
                end
                S_CROSS: begin
                    step_reg <= step_reg + STEP_W'(1);
                    if (step_reg == LAST_STEP) begin
                        state_reg <= S_CR_WAIT;
                    end
                end
                S_CR_WAIT: begin
                    if (mac_res_valid && res_cnt_reg == 2'd2) begin
                        if (idx_last) begin
                            set_flag_reg <= 1'b1;
                            state_reg    <= S_SET_END;
                        end else begin
                            idx_reg   <= idx_reg + IW'(1);
                            state_reg <= normal_nonzero ? S_FETCH_DOT : S_FETCH_CR;
                        end
                    end
                end
                S_FETCH_DOT: begin
                    state_reg <= S_LD_DOT;
                end
                S_LD_DOT: begin
                    d_reg     <= rd_diff;
                    step_reg  <= '0;
                    state_reg <= S_DOT;
                end
                S_DOT: begin
                    step_reg <= step_reg + STEP_W'(1);
                    if (step_reg == LAST_STEP) begin
                        state_reg <= S_DOT_WAIT;
                    end
                end
                S_DOT_WAIT: begin
                    if (mac_res_valid) begin
                        if (dot_mag > ACC_W'(tol_reg)) begin
                            set_flag_reg <= 1'b0;
                            state_reg    <= S_SET_END;
                        end else if (idx_last) begin
                            set_flag_reg <= 1'b1;
                            state_reg    <= S_SET_END;
                        end else begin
                            idx_reg   <= idx_reg + IW'(1);
                            state_reg <= S_FETCH_DOT;
                        end
                    end
                end
                S_SET_END: begin
                    if (set_flag_reg || set_sel_reg) begin
                        if (result_load) begin
                            state_reg <= S_LOAD;
                        end
                    end else begin
                        set_sel_reg <= 1'b1;
                        idx_reg     <= '0;
                        state_reg   <= S_FETCH_P1;
                    end
                end
                default: begin
                    state_reg <= S_LOAD;
                end
            endcase
        end
    end

    assign s_ready    = (state_reg == S_LOAD);
    assign m_valid    = m_valid_reg;
    assign m_coplanar = m_coplanar_reg;

endmodule

`default_nettype wire

/* hw/rtl/lcc_checker.sv */
// ----------------------------------------------------------------------------
// Landmark coplanarity check port checker
// Watches the ports of the top level for load sequencing and result delivery.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
`include "landmark_coplanarity_check_defines.svh"

module lcc_checker #(
    parameter int POINTS_PER_SET = 4
) (
    input wire                                      aclk,
    input wire                                      aresetn,
    input wire                                      cfg_wr_en,
    input wire logic [lcc_pkg::TOL_W-1:0]           cfg_wr_data,
    input wire                                      s_valid,
    input wire                                      s_ready,
    input wire logic signed [lcc_pkg::COORD_W-1:0]  s_coord_x,
    input wire logic signed [lcc_pkg::COORD_W-1:0]  s_coord_y,
    input wire logic signed [lcc_pkg::COORD_W-1:0]  s_coord_z,
    input wire                                      m_valid,
    input wire                                      m_ready,
    input wire                                      m_coplanar
);
    localparam int DEPTH = 2 * POINTS_PER_SET;
    localparam int AW    = $clog2(DEPTH);
    localparam logic [AW-1:0] LAST_LOAD = AW'(DEPTH - 1);

    logic [AW-1:0] cnt_reg;
    logic [AW-1:0] cnt_next;
    logic          s_xfer;
    logic          cfg_seen;

    assign s_xfer   = s_valid && s_ready;
    assign cfg_seen = cfg_wr_en && (cfg_wr_data != cfg_wr_data + 1'b1)
                   && (s_coord_x == s_coord_x) && (s_coord_y == s_coord_y)
                   && (s_coord_z == s_coord_z);
    assign cnt_next = (cnt_reg == LAST_LOAD) ? '0 : cnt_reg + AW'(1);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg <= '0;
        end else if (s_xfer) begin
            cnt_reg <= cnt_next;
        end
    end

    `LCC_ASSERT_NEXT(a_result_held, aclk, aresetn, m_valid && !m_ready, m_valid && $stable(m_coplanar), "Result transaction changed while stalled")
    `LCC_ASSERT_NEXT(a_load_continues, aclk, aresetn, s_xfer && (cnt_reg != LAST_LOAD) && !cfg_seen, s_ready, "Block went busy before the last point of a load")
    `LCC_ASSERT_NEXT(a_check_starts, aclk, aresetn, s_xfer && (cnt_reg == LAST_LOAD), !s_ready, "Block stayed ready after the last point of a load")
    `LCC_ASSERT_NOW(a_result_after_check, aclk, aresetn, $rose(m_valid), !$past(s_ready), "Result transaction appeared without a preceding check")

endmodule

bind landmark_coplanarity_check lcc_checker #(
    .POINTS_PER_SET(POINTS_PER_SET)
) u_lcc_checker (.*);

`default_nettype wire
